// ===== rtl/core/crscb_pkg.sv =====
package crscb_pkg;

    localparam int unsigned CFG_DATA_W  = 7;
    localparam int unsigned CFG_INDEX_W = 2;

    localparam logic [31:0] PREFIX_WORD = 32'h1200_0000;

    localparam logic [3:0] MODE_FAN_ONLY = 4'd1;
    localparam logic [3:0] MODE_DRY      = 4'd2;
    localparam logic [3:0] MODE_COOL     = 4'd8;

    localparam logic [3:0] FAN_HIGH   = 4'd1;
    localparam logic [3:0] FAN_MEDIUM = 4'd2;
    localparam logic [3:0] FAN_LOW    = 4'd4;

    localparam logic [3:0] MAX_HOURS = 4'd12;

    localparam logic [7:0] SETPOINT_RESET = 8'd24;
    localparam logic [5:0] MIN_C_RESET    = 6'd16;
    localparam logic [5:0] MAX_C_RESET    = 6'd32;
    localparam logic [6:0] MIN_F_RESET    = 7'd61;
    localparam logic [6:0] MAX_F_RESET    = 7'd89;

    typedef enum logic [3:0] {
        ACT_SET_POWER   = 4'd0,
        ACT_NEXT_MODE   = 4'd1,
        ACT_NEXT_FAN    = 4'd2,
        ACT_TEMP_UP     = 4'd3,
        ACT_TEMP_DOWN   = 4'd4,
        ACT_TOGGLE_UNIT = 4'd5,
        ACT_SET_TIMER   = 4'd6,
        ACT_SET_HOURS   = 4'd7,
        ACT_SEND        = 4'd8
    } t_action;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MIN_C = 2'd0,
        CFG_MAX_C = 2'd1,
        CFG_MIN_F = 2'd2,
        CFG_MAX_F = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [3:0] action;
        logic       flag_value;
        logic [3:0] hours_value;
    } t_in_item;

    typedef struct packed {
        logic        power_is_on;
        logic        timer_is_enabled;
        logic        unit_is_fahrenheit;
        logic [7:0]  setpoint;
        logic [3:0]  mode_now;
        logic [3:0]  fan_now;
        logic [3:0]  hours_now;
        logic [31:0] payload_word;
        logic        payload_valid;
    } t_out_item;

    typedef struct packed {
        logic [5:0] min_c;
        logic [5:0] max_c;
        logic [6:0] min_f;
        logic [6:0] max_f;
    } t_cfg_limits;

    typedef struct packed {
        logic       power;
        logic       timer;
        logic       fahrenheit;
        logic [7:0] setpoint;
        logic [3:0] mode;
        logic [3:0] fan;
        logic [3:0] hours;
    } t_settings;

endpackage

// ===== rtl/core/crscb_cfg.sv =====
module crscb_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [crscb_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [crscb_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output crscb_pkg::t_cfg_limits              o_limits
);

    crscb_pkg::t_cfg_limits r_limits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.min_c <= crscb_pkg::MIN_C_RESET;
            r_limits.max_c <= crscb_pkg::MAX_C_RESET;
            r_limits.min_f <= crscb_pkg::MIN_F_RESET;
            r_limits.max_f <= crscb_pkg::MAX_F_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                crscb_pkg::CFG_MIN_C: r_limits.min_c <= i_cfg_data[5:0];
                crscb_pkg::CFG_MAX_C: r_limits.max_c <= i_cfg_data[5:0];
                crscb_pkg::CFG_MIN_F: r_limits.min_f <= i_cfg_data;
                crscb_pkg::CFG_MAX_F: r_limits.max_f <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_limits = r_limits;

endmodule

// ===== rtl/core/crscb_convert.sv =====
module crscb_convert (
    input  logic [7:0] i_setpoint,
    output logic [7:0] o_to_fahrenheit,
    output logic [7:0] o_to_celsius
);

    logic [12:0] c_num;
    logic [25:0] c_prod;
    logic [9:0]  f_full;
    logic [7:0]  f_delta;
    logic [11:0] f_num;
    logic [23:0] f_prod;

    // Division by ten and by eighteen is done as a multiply by a scaled
    // reciprocal; the error stays well below one step over the input range.
    always_comb begin
        c_num  = {5'b0, i_setpoint} * 13'd18 + 13'd5;
        c_prod = {13'b0, c_num} * 26'd6554;
        f_full = c_prod[25:16] + 10'd32;
        o_to_fahrenheit = (f_full > 10'd255) ? 8'd255 : f_full[7:0];

        f_delta = i_setpoint - 8'd32;
        f_num   = {4'b0, f_delta} * 12'd10 + 12'd9;
        f_prod  = {12'b0, f_num} * 24'd3641;
        o_to_celsius = (i_setpoint >= 8'd32) ? f_prod[23:16] : 8'd0;
    end

endmodule

// ===== rtl/core/crscb_payload.sv =====
module crscb_payload (
    input  crscb_pkg::t_settings i_settings,
    output logic [31:0]          o_word
);

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

    logic [7:0] temp_code;
    logic [3:0] mode_code;
    logic [3:0] fan_code;
    logic [3:0] hours_rev;

    always_comb begin
        temp_code = i_settings.fahrenheit ? i_settings.setpoint
                                          : i_settings.setpoint - 8'd16;
        if (i_settings.mode == crscb_pkg::MODE_COOL || i_settings.mode == crscb_pkg::MODE_DRY
                || i_settings.mode == crscb_pkg::MODE_FAN_ONLY) begin
            mode_code = i_settings.mode;
        end else begin
            mode_code = crscb_pkg::MODE_COOL;
        end
        if (i_settings.fan == crscb_pkg::FAN_LOW || i_settings.fan == crscb_pkg::FAN_MEDIUM
                || i_settings.fan == crscb_pkg::FAN_HIGH) begin
            fan_code = i_settings.fan;
        end else begin
            fan_code = crscb_pkg::FAN_MEDIUM;
        end
        hours_rev = {i_settings.hours[0], i_settings.hours[1],
                     i_settings.hours[2], i_settings.hours[3]};
        o_word = crscb_pkg::PREFIX_WORD
               | {8'b0, fan_code, mode_code, hours_rev, 1'b0, i_settings.fahrenheit,
                  i_settings.timer, i_settings.power, rev8(temp_code)};
    end

endmodule

// ===== rtl/core/crscb_step.sv =====
module crscb_step (
    input  crscb_pkg::t_settings   i_settings,
    input  crscb_pkg::t_cfg_limits i_limits,
    input  crscb_pkg::t_in_item    i_item,
    output crscb_pkg::t_settings   o_settings,
    output logic [31:0]            o_word,
    output logic                   o_word_valid
);

    logic [7:0]           to_f;
    logic [7:0]           to_c;
    logic [7:0]           lo;
    logic [7:0]           hi;
    crscb_pkg::t_settings clamped;
    logic [31:0]          word;

    crscb_convert u_convert (
        .i_setpoint      (i_settings.setpoint),
        .o_to_fahrenheit (to_f),
        .o_to_celsius    (to_c)
    );

    always_comb begin
        lo = i_settings.fahrenheit ? {1'b0, i_limits.min_f} : {2'b0, i_limits.min_c};
        hi = i_settings.fahrenheit ? {1'b0, i_limits.max_f} : {2'b0, i_limits.max_c};
        clamped = i_settings;
        // Lower limit first: with crossed limits, a setpoint below it takes it; any other takes the upper.
        if (i_settings.setpoint < lo) begin
            clamped.setpoint = lo;
        end else if (i_settings.setpoint > hi) begin
            clamped.setpoint = hi;
        end
    end

    crscb_payload u_payload (
        .i_settings (clamped),
        .o_word     (word)
    );

    always_comb begin
        o_settings   = i_settings;
        o_word       = 32'd0;
        o_word_valid = 1'b0;
        unique case (i_item.action)
            crscb_pkg::ACT_SET_POWER: o_settings.power = i_item.flag_value;
            crscb_pkg::ACT_NEXT_MODE: begin
                case (i_settings.mode)
                    crscb_pkg::MODE_FAN_ONLY: o_settings.mode = crscb_pkg::MODE_DRY;
                    crscb_pkg::MODE_DRY:      o_settings.mode = crscb_pkg::MODE_COOL;
                    crscb_pkg::MODE_COOL:     o_settings.mode = crscb_pkg::MODE_FAN_ONLY;
                    default: ;
                endcase
            end
            crscb_pkg::ACT_NEXT_FAN: begin
                case (i_settings.fan)
                    crscb_pkg::FAN_HIGH:   o_settings.fan = crscb_pkg::FAN_LOW;
                    crscb_pkg::FAN_MEDIUM: o_settings.fan = crscb_pkg::FAN_HIGH;
                    crscb_pkg::FAN_LOW:    o_settings.fan = crscb_pkg::FAN_MEDIUM;
                    default: ;
                endcase
            end
            crscb_pkg::ACT_TEMP_UP: begin
                if (i_settings.setpoint < hi) begin
                    o_settings.setpoint = i_settings.setpoint + 8'd1;
                end
            end
            crscb_pkg::ACT_TEMP_DOWN: begin
                if (i_settings.setpoint > lo) begin
                    o_settings.setpoint = i_settings.setpoint - 8'd1;
                end
            end
            crscb_pkg::ACT_TOGGLE_UNIT: begin
                o_settings.fahrenheit = !i_settings.fahrenheit;
                o_settings.setpoint   = i_settings.fahrenheit ? to_c : to_f;
            end
            crscb_pkg::ACT_SET_TIMER: o_settings.timer = i_item.flag_value;
            crscb_pkg::ACT_SET_HOURS: begin
                if (i_item.hours_value <= crscb_pkg::MAX_HOURS) begin
                    o_settings.hours = i_item.hours_value;
                end
            end
            crscb_pkg::ACT_SEND: begin
                o_settings   = clamped;
                o_word       = word;
                o_word_valid = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/core/climate_remote_state_and_code_builder.sv =====
// Climate remote settings keeper and IR code builder.
//
// Input channel (i_in_valid / o_in_ready / i_in_item) carries one button
// action per beat. Every accepted beat produces exactly one result beat on
// the output channel (o_out_valid / i_out_ready / o_out_item), holding the
// settings after the action and, for a send, the 32-bit IR payload.
// The settings and the result register load on the edge that accepts the beat.
// Throughput is one beat per cycle while the receiver takes results; the
// combinational path is the clamp, unit conversion multiply and payload mux.
// o_in_ready is high while the result register is empty or being taken, so a
// stalled receiver holds its result and the input waits behind it.
// The plain write port (i_cfg_we, i_cfg_index, i_cfg_data) sets the
// temperature limits; write it only while no result is outstanding.
// Synchronous reset restores the limits and settings to their defaults
// (off, cooling, medium fan, 24 Celsius, timer off at zero hours) and
// empties the result register.
module climate_remote_state_and_code_builder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  crscb_pkg::t_in_item                 i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output crscb_pkg::t_out_item                o_out_item,
    input  logic                                i_cfg_we,
    input  logic [crscb_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [crscb_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    crscb_pkg::t_cfg_limits limits;
    crscb_pkg::t_settings   r_settings;
    crscb_pkg::t_settings   n_settings;
    crscb_pkg::t_out_item   r_out_item;
    logic                   r_out_valid;
    logic [31:0]            word;
    logic                   word_valid;
    logic                   accept;

    crscb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_limits    (limits)
    );

    crscb_step u_step (
        .i_settings   (r_settings),
        .i_limits     (limits),
        .i_item       (i_in_item),
        .o_settings   (n_settings),
        .o_word       (word),
        .o_word_valid (word_valid)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settings.power      <= 1'b0;
            r_settings.timer      <= 1'b0;
            r_settings.fahrenheit <= 1'b0;
            r_settings.setpoint   <= crscb_pkg::SETPOINT_RESET;
            r_settings.mode       <= crscb_pkg::MODE_COOL;
            r_settings.fan        <= crscb_pkg::FAN_MEDIUM;
            r_settings.hours      <= 4'd0;
            r_out_valid           <= 1'b0;
        end else begin
            if (accept) begin
                r_settings  <= n_settings;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_item.power_is_on        <= n_settings.power;
            r_out_item.timer_is_enabled   <= n_settings.timer;
            r_out_item.unit_is_fahrenheit <= n_settings.fahrenheit;
            r_out_item.setpoint           <= n_settings.setpoint;
            r_out_item.mode_now           <= n_settings.mode;
            r_out_item.fan_now            <= n_settings.fan;
            r_out_item.hours_now          <= n_settings.hours;
            r_out_item.payload_word       <= word;
            r_out_item.payload_valid      <= word_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== rtl/core/crscb_checker.sv =====
module crscb_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input crscb_pkg::t_out_item o_out_item
);

    // A result waiting on a stalled receiver must hold still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result beat changed while stalled");

    // The result register is empty after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    // An accepted input beat always leaves a result behind it.
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted beat produced no result");

    // Non-send results carry an empty payload; send results carry the prefix.
    a_payload_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.payload_valid
                         ? (o_out_item.payload_word[31:24] == 8'h12)
                         : (o_out_item.payload_word == 32'd0)))
        else $error("payload word inconsistent with payload valid");

    // A send carries the shown unit and power in its flag bits.
    a_payload_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.payload_valid
            |-> o_out_item.payload_word[10] == o_out_item.unit_is_fahrenheit
             && o_out_item.payload_word[8] == o_out_item.power_is_on)
        else $error("payload flag bits disagree with settings");

endmodule

bind climate_remote_state_and_code_builder crscb_checker u_crscb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

// ===== tb/climate_remote_state_and_code_builder_test.sv =====
module climate_remote_state_and_code_builder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import crscb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEMS_PER_SEGMENT = 190;
    localparam int SEGMENTS = 8;

    typedef struct {
        bit         is_limit;
        t_cfg_index limit_sel;
        logic [6:0] limit_value;
        t_in_item   button;
        bit         typed;
        t_out_item  readout;
    } t_script_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    t_in_item               i_in_item = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    t_out_item              o_out_item;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    t_settings   remote;
    t_cfg_limits limits;
    t_out_item   pending_readouts [$];
    t_script_row script [$];
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          failures = 0;
    int          cycles = 0;

    climate_remote_state_and_code_builder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL climate_remote_state_and_code_builder");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99, 0) >= stall_pct);
    end

    function automatic logic [7:0] flip_byte(logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7 - i];
        end
        return r;
    endfunction

    // Advances the remote settings by one button beat and returns the readout.
    function automatic t_out_item apply_button(t_in_item it);
        t_out_item  r;
        logic [7:0] lo;
        logic [7:0] hi;
        int         t;
        r = '0;
        lo = remote.fahrenheit ? {1'b0, limits.min_f} : {2'b0, limits.min_c};
        hi = remote.fahrenheit ? {1'b0, limits.max_f} : {2'b0, limits.max_c};
        case (it.action)
            ACT_SET_POWER: begin
                remote.power = it.flag_value;
            end
            ACT_NEXT_MODE: begin
                case (remote.mode)
                    MODE_FAN_ONLY: remote.mode = MODE_DRY;
                    MODE_DRY:      remote.mode = MODE_COOL;
                    MODE_COOL:     remote.mode = MODE_FAN_ONLY;
                    default:       ;
                endcase
            end
            ACT_NEXT_FAN: begin
                case (remote.fan)
                    FAN_HIGH:   remote.fan = FAN_LOW;
                    FAN_MEDIUM: remote.fan = FAN_HIGH;
                    FAN_LOW:    remote.fan = FAN_MEDIUM;
                    default:    ;
                endcase
            end
            ACT_TEMP_UP: begin
                if (remote.setpoint < hi) remote.setpoint = remote.setpoint + 8'd1;
            end
            ACT_TEMP_DOWN: begin
                if (remote.setpoint > lo) remote.setpoint = remote.setpoint - 8'd1;
            end
            ACT_TOGGLE_UNIT: begin
                t = int'(remote.setpoint);
                if (remote.fahrenheit) begin
                    remote.setpoint = (t >= 32) ? 8'((10 * (t - 32) + 9) / 18) : 8'd0;
                    remote.fahrenheit = 1'b0;
                end else begin
                    t = (18 * t + 5) / 10 + 32;
                    remote.setpoint = (t > 255) ? 8'd255 : 8'(t);
                    remote.fahrenheit = 1'b1;
                end
            end
            ACT_SET_TIMER: begin
                remote.timer = it.flag_value;
            end
            ACT_SET_HOURS: begin
                if (it.hours_value <= MAX_HOURS) remote.hours = it.hours_value;
            end
            ACT_SEND: begin
                if (remote.setpoint < lo) remote.setpoint = lo;
                else if (remote.setpoint > hi) remote.setpoint = hi;
                r.payload_word = PREFIX_WORD;
                // Celsius is sent as an offset from sixteen, wrapping below it.
                r.payload_word[7:0] = flip_byte(remote.fahrenheit ? remote.setpoint
                                                                  : remote.setpoint - 8'd16);
                r.payload_word[15:8] = flip_byte({4'd0, remote.hours});
                r.payload_word[8] = remote.power;
                r.payload_word[9] = remote.timer;
                r.payload_word[10] = remote.fahrenheit;
                r.payload_word[19:16] = (remote.mode == MODE_COOL || remote.mode == MODE_DRY ||
                                         remote.mode == MODE_FAN_ONLY) ? remote.mode : MODE_COOL;
                r.payload_word[23:20] = (remote.fan == FAN_LOW || remote.fan == FAN_MEDIUM ||
                                         remote.fan == FAN_HIGH) ? remote.fan : FAN_MEDIUM;
                r.payload_valid = 1'b1;
            end
            default: ;
        endcase
        r.power_is_on = remote.power;
        r.timer_is_enabled = remote.timer;
        r.unit_is_fahrenheit = remote.fahrenheit;
        r.setpoint = remote.setpoint;
        r.mode_now = remote.mode;
        r.fan_now = remote.fan;
        r.hours_now = remote.hours;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge i_clk) begin : readout_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_readouts.size() == 0) begin
                $error("result beat arrived with no readout pending");
                failures++;
            end else begin
                want = pending_readouts.pop_front();
                check_field("power_is_on", want.power_is_on, o_out_item.power_is_on);
                check_field("timer_is_enabled", want.timer_is_enabled,
                            o_out_item.timer_is_enabled);
                check_field("unit_is_fahrenheit", want.unit_is_fahrenheit,
                            o_out_item.unit_is_fahrenheit);
                check_field("setpoint", want.setpoint, o_out_item.setpoint);
                check_field("mode_now", want.mode_now, o_out_item.mode_now);
                check_field("fan_now", want.fan_now, o_out_item.fan_now);
                check_field("hours_now", want.hours_now, o_out_item.hours_now);
                check_field("payload_word", want.payload_word, o_out_item.payload_word);
                check_field("payload_valid", want.payload_valid, o_out_item.payload_valid);
            end
        end
    end

    // Called at a clock edge; returns at the edge that accepts the beat, leaving
    // valid high so that a following beat can go out back to back.
    task automatic press_button(t_in_item it, bit typed, t_out_item typed_readout);
        t_out_item predicted;
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = apply_button(it);
        pending_readouts.push_back(typed ? typed_readout : predicted);
    endtask

    task automatic wait_for_readouts();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_readouts.size() != 0);
    endtask

    task automatic program_limit(t_cfg_index sel, logic [6:0] value);
        wait_for_readouts();
        repeat (2) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (sel)
            CFG_MIN_C: limits.min_c = value[5:0];
            CFG_MAX_C: limits.max_c = value[5:0];
            CFG_MIN_F: limits.min_f = value;
            CFG_MAX_F: limits.max_f = value;
            default:   ;
        endcase
    endtask

    function automatic t_script_row press_row(logic [3:0] act, logic flag, logic [3:0] hrs);
        t_script_row row;
        row.is_limit = 1'b0;
        row.limit_sel = CFG_MIN_C;
        row.limit_value = '0;
        row.button = t_in_item'{act, flag, hrs};
        row.typed = 1'b0;
        row.readout = '0;
        return row;
    endfunction

    function automatic t_script_row checked_row(logic [3:0] act, logic flag, logic [3:0] hrs,
                                                t_out_item readout);
        t_script_row row;
        row = press_row(act, flag, hrs);
        row.typed = 1'b1;
        row.readout = readout;
        return row;
    endfunction

    function automatic t_script_row limit_row(t_cfg_index sel, int value);
        t_script_row row;
        row = press_row(ACT_SEND, 1'b0, 4'd0);
        row.is_limit = 1'b1;
        row.limit_sel = sel;
        row.limit_value = 7'(value);
        return row;
    endfunction

    initial begin : stimulus
        t_in_item item;
        int       count;
        int       burst;
        int       pick;
        int       lim [4];
        remote = t_settings'{1'b0, 1'b0, 1'b0, SETPOINT_RESET, MODE_COOL, FAN_MEDIUM, 4'd0};
        limits = t_cfg_limits'{MIN_C_RESET, MAX_C_RESET, MIN_F_RESET, MAX_F_RESET};

        // Reset values, an unknown action and the ignored hours are typed in.
        script.push_back(checked_row(ACT_SEND, 1'b0, 4'd0, t_out_item'{1'b0, 1'b0, 1'b0,
            SETPOINT_RESET, MODE_COOL, FAN_MEDIUM, 4'd0, 32'h1228_0010, 1'b1}));
        script.push_back(checked_row(4'd15, 1'b1, 4'd15, t_out_item'{1'b0, 1'b0, 1'b0,
            SETPOINT_RESET, MODE_COOL, FAN_MEDIUM, 4'd0, 32'd0, 1'b0}));
        script.push_back(checked_row(ACT_SET_POWER, 1'b1, 4'd0, t_out_item'{1'b1, 1'b0, 1'b0,
            SETPOINT_RESET, MODE_COOL, FAN_MEDIUM, 4'd0, 32'd0, 1'b0}));
        script.push_back(checked_row(ACT_SET_TIMER, 1'b1, 4'd9, t_out_item'{1'b1, 1'b1, 1'b0,
            SETPOINT_RESET, MODE_COOL, FAN_MEDIUM, 4'd0, 32'd0, 1'b0}));
        script.push_back(checked_row(ACT_SET_HOURS, 1'b0, 4'd12, t_out_item'{1'b1, 1'b1, 1'b0,
            SETPOINT_RESET, MODE_COOL, FAN_MEDIUM, MAX_HOURS, 32'd0, 1'b0}));
        script.push_back(checked_row(ACT_SET_HOURS, 1'b1, 4'd15, t_out_item'{1'b1, 1'b1, 1'b0,
            SETPOINT_RESET, MODE_COOL, FAN_MEDIUM, MAX_HOURS, 32'd0, 1'b0}));
        script.push_back(press_row(ACT_SET_HOURS, 1'b0, 4'd13));
        script.push_back(press_row(ACT_SEND, 1'b1, 4'd5));
        repeat (3) script.push_back(press_row(ACT_NEXT_MODE, 1'b0, 4'd0));
        repeat (3) script.push_back(press_row(ACT_NEXT_FAN, 1'b1, 4'd10));
        // Both Celsius limits pinned at the setpoint, so neither step moves it.
        script.push_back(limit_row(CFG_MIN_C, 24));
        script.push_back(limit_row(CFG_MAX_C, 24));
        script.push_back(press_row(ACT_TEMP_UP, 1'b0, 4'd0));
        script.push_back(press_row(ACT_TEMP_DOWN, 1'b0, 4'd0));
        // Minimum above maximum: the send clamp lets the minimum win.
        script.push_back(limit_row(CFG_MIN_C, 40));
        script.push_back(limit_row(CFG_MAX_C, 0));
        script.push_back(press_row(ACT_SEND, 1'b0, 4'd3));
        script.push_back(press_row(ACT_TOGGLE_UNIT, 1'b0, 4'd0));
        script.push_back(limit_row(CFG_MIN_F, 32));
        script.push_back(limit_row(CFG_MAX_F, 104));
        script.push_back(press_row(ACT_TEMP_UP, 1'b1, 4'd0));
        script.push_back(press_row(ACT_TOGGLE_UNIT, 1'b0, 4'd0));
        // A Celsius setpoint of zero wraps the offset byte in the payload.
        script.push_back(limit_row(CFG_MIN_C, 0));
        script.push_back(limit_row(CFG_MAX_C, 0));
        script.push_back(press_row(ACT_SEND, 1'b1, 4'd8));
        script.push_back(press_row(ACT_TOGGLE_UNIT, 1'b0, 4'd0));
        script.push_back(press_row(ACT_TEMP_DOWN, 1'b0, 4'd0));
        script.push_back(press_row(ACT_SET_POWER, 1'b0, 4'd15));
        script.push_back(press_row(ACT_SET_TIMER, 1'b0, 4'd6));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].is_limit) begin
                program_limit(script[i].limit_sel, script[i].limit_value);
            end else begin
                press_button(script[i].button, script[i].typed, script[i].readout);
            end
        end

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg)
                0, 7: lim = '{16, 32, 61, 89};
                1:    lim = '{0, 40, 32, 104};
                3:    lim = '{40, 0, 104, 32};
                5: begin
                    lim[0] = $urandom_range(40, 0);
                    lim[1] = lim[0];
                    lim[2] = $urandom_range(104, 32);
                    lim[3] = lim[2];
                end
                default: begin
                    lim[0] = $urandom_range(40, 0);
                    lim[1] = $urandom_range(40, 0);
                    lim[2] = $urandom_range(104, 32);
                    lim[3] = $urandom_range(104, 32);
                end
            endcase
            program_limit(CFG_MIN_C, 7'(lim[0]));
            program_limit(CFG_MAX_C, 7'(lim[1]));
            program_limit(CFG_MIN_F, 7'(lim[2]));
            program_limit(CFG_MAX_F, 7'(lim[3]));
            case (seg % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 53; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 53; end
                default: begin send_idle_pct = 21; stall_pct = 21; end
            endcase

            count = 0;
            while (count < ITEMS_PER_SEGMENT) begin
                pick = $urandom_range(99, 0);
                item.action = (pick < 5) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8, 0));
                // Runs of steps are needed to walk the setpoint onto its limits.
                burst = (item.action == ACT_TEMP_UP || item.action == ACT_TEMP_DOWN) ?
                        $urandom_range(12, 1) : 1;
                repeat (burst) begin
                    item.flag_value = 1'($urandom_range(1, 0));
                    item.hours_value = 4'($urandom_range(15, 0));
                    press_button(item, 1'b0, '0);
                    count++;
                end
                if ($urandom_range(199, 0) == 0) wait_for_readouts();
            end
        end

        wait_for_readouts();
        repeat (4) @(posedge i_clk);
        if (pending_readouts.size() != 0) begin
            $error("%0d readouts never arrived", pending_readouts.size());
            failures++;
        end
        if (failures == 0) begin
            $display("PASS climate_remote_state_and_code_builder");
        end else begin
            $display("FAIL climate_remote_state_and_code_builder");
        end
        $finish;
    end

endmodule
